// ----- hdl/pixel_to_ansi_truecolor_stream_assert.svh -----
// Assertion macros for the terminal color stream block
`ifndef PIXEL_TO_ANSI_TRUECOLOR_STREAM_ASSERT_SVH
`define PIXEL_TO_ANSI_TRUECOLOR_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PTAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PTAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ptat_pkg.sv -----
`default_nettype none
package ptat_pkg;

  localparam int unsigned CFG_W             = 13;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd80;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd24;
  localparam int unsigned MAX_DIMENSION_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned NSTEP             = 28;
  localparam int unsigned STEP_W            = 5;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LB    = 8'h5b;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [STEP_W-1:0] {
    ST_HOME_ESC, ST_HOME_LB, ST_HOME_H,
    ST_COL_ESC, ST_COL_LB, ST_COL_4, ST_COL_8, ST_COL_SEMI_A, ST_COL_2, ST_COL_SEMI_B,
    ST_R_H, ST_R_T, ST_R_U, ST_R_TERM,
    ST_G_H, ST_G_T, ST_G_U, ST_G_TERM,
    ST_B_H, ST_B_T, ST_B_U, ST_B_TERM,
    ST_GLYPH, ST_NEWLINE,
    ST_END_ESC, ST_END_LB, ST_END_0, ST_END_M
  } step_t;

  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] u;
  } digits_t;

  typedef struct packed {
    logic [NSTEP-1:0] mask;
    digits_t          red_d;
    digits_t          green_d;
    digits_t          blue_d;
    logic [7:0]       glyph;
  } cmd_t;

  function automatic digits_t to_digits(input logic [7:0] v);
    logic [13:0] p_h;
    logic [6:0]  rem;
    logic [14:0] p_t;
    digits_t     d;
    p_h = 14'(v) * 14'd41;
    d.h = {2'b00, p_h[13:12]};
    rem = 7'(v - 8'(d.h) * 8'd100);
    p_t = 15'(rem) * 15'd205;
    d.t = p_t[14:11];
    d.u = 4'(rem - 7'(d.t) * 7'd10);
    return d;
  endfunction

  function automatic logic [7:0] step_byte(input step_t s, input cmd_t c);
    logic [7:0] b;
    unique case (s)
      ST_HOME_ESC, ST_COL_ESC, ST_END_ESC:             b = CH_ESC;
      ST_HOME_LB, ST_COL_LB, ST_END_LB:                b = CH_LB;
      ST_HOME_H:                                       b = CH_H;
      ST_COL_4:                                        b = CH_FOUR;
      ST_COL_8:                                        b = CH_EIGHT;
      ST_COL_2:                                        b = CH_TWO;
      ST_COL_SEMI_A, ST_COL_SEMI_B, ST_R_TERM, ST_G_TERM: b = CH_SEMI;
      ST_B_TERM, ST_END_M:                             b = CH_M;
      ST_END_0:                                        b = CH_ZERO;
      ST_R_H:                                          b = {4'h3, c.red_d.h};
      ST_R_T:                                          b = {4'h3, c.red_d.t};
      ST_R_U:                                          b = {4'h3, c.red_d.u};
      ST_G_H:                                          b = {4'h3, c.green_d.h};
      ST_G_T:                                          b = {4'h3, c.green_d.t};
      ST_G_U:                                          b = {4'h3, c.green_d.u};
      ST_B_H:                                          b = {4'h3, c.blue_d.h};
      ST_B_T:                                          b = {4'h3, c.blue_d.t};
      ST_B_U:                                          b = {4'h3, c.blue_d.u};
      ST_GLYPH:                                        b = c.glyph;
      ST_NEWLINE:                                      b = CH_NL;
      default:                                         b = CH_SPACE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ptat_if.sv -----
`default_nettype none
interface ptat_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] glyph;

  modport source (output valid, red, green, blue, glyph, input ready);
  modport sink (input valid, red, green, blue, glyph, output ready);
endinterface

interface ptat_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_done;

  modport source (output valid, out_byte, last_of_run, frame_done, input ready);
  modport sink (input valid, out_byte, last_of_run, frame_done, output ready);
endinterface
`default_nettype wire

// ----- hdl/ptat_queue.sv -----
`default_nettype none
module ptat_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptat_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output logic            head_valid,
  output ptat_pkg::cmd_t  head_cmd
);
  import ptat_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ptat_front.sv -----
`default_nettype none
module ptat_front #(
  parameter int unsigned MAX_DIMENSION = ptat_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptat_pix_if.sink                       in_pix,
  input  logic                           cfg_we,
  input  logic [ptat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptat_pkg::CFG_W-1:0]     cfg_data,
  output logic                           push,
  output ptat_pkg::cmd_t                 push_cmd,
  input  logic                           push_ready
);
  import ptat_pkg::*;

  localparam int unsigned EFF_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CMP_W = (EFF_W > CFG_W) ? EFF_W : CFG_W;
  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
  localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(MAX_DIMENSION);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [23:0]      prev_r, prev_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0] w_ext, h_ext, eff_w, eff_h;
  logic [CMP_W:0]   col_inc, row_inc;
  logic [23:0]      color;
  logic             home, chg, row_end, frame_end;
  digits_t          red_d, green_d, blue_d;
  logic [3:0]       red_s, green_s, blue_s;

  function automatic logic [3:0] comp_steps(input logic [7:0] v, input digits_t d);
    return {1'b1, v != 8'd0, (d.h != 4'd0) || (d.t != 4'd0), d.h != 4'd0};
  endfunction

  assign in_pix.ready = push_ready;
  assign push         = in_pix.valid && push_ready;

  always_comb begin
    w_ext = CMP_W'(width_r);
    h_ext = CMP_W'(height_r);
    eff_w = (w_ext == '0) ? CMP_W'(1) : ((w_ext > MAX_DIM) ? MAX_DIM : w_ext);
    eff_h = (h_ext == '0) ? CMP_W'(1) : ((h_ext > MAX_DIM) ? MAX_DIM : h_ext);
    col_inc   = (CMP_W + 1)'(col_r) + 1'b1;
    row_inc   = (CMP_W + 1)'(row_r) + 1'b1;
    color     = {in_pix.red, in_pix.green, in_pix.blue};
    home      = (col_r == '0) && (row_r == '0);
    chg       = (color != prev_r);
    row_end   = (col_inc >= {1'b0, eff_w});
    frame_end = row_end && (row_inc >= {1'b0, eff_h});
    red_d     = to_digits(in_pix.red);
    green_d   = to_digits(in_pix.green);
    blue_d    = to_digits(in_pix.blue);
    red_s     = comp_steps(in_pix.red, red_d) & {4{chg}};
    green_s   = comp_steps(in_pix.green, green_d) & {4{chg}};
    blue_s    = comp_steps(in_pix.blue, blue_d) & {4{chg}};
  end

  always_comb begin
    push_cmd.mask                = '0;
    push_cmd.mask[ST_HOME_ESC]   = home;
    push_cmd.mask[ST_HOME_LB]    = home;
    push_cmd.mask[ST_HOME_H]     = home;
    push_cmd.mask[ST_COL_ESC]    = chg;
    push_cmd.mask[ST_COL_LB]     = chg;
    push_cmd.mask[ST_COL_4]      = chg;
    push_cmd.mask[ST_COL_8]      = chg;
    push_cmd.mask[ST_COL_SEMI_A] = chg;
    push_cmd.mask[ST_COL_2]      = chg;
    push_cmd.mask[ST_COL_SEMI_B] = chg;
    push_cmd.mask[ST_R_H]        = red_s[0];
    push_cmd.mask[ST_R_T]        = red_s[1];
    push_cmd.mask[ST_R_U]        = red_s[2];
    push_cmd.mask[ST_R_TERM]     = red_s[3];
    push_cmd.mask[ST_G_H]        = green_s[0];
    push_cmd.mask[ST_G_T]        = green_s[1];
    push_cmd.mask[ST_G_U]        = green_s[2];
    push_cmd.mask[ST_G_TERM]     = green_s[3];
    push_cmd.mask[ST_B_H]        = blue_s[0];
    push_cmd.mask[ST_B_T]        = blue_s[1];
    push_cmd.mask[ST_B_U]        = blue_s[2];
    push_cmd.mask[ST_B_TERM]     = blue_s[3];
    push_cmd.mask[ST_GLYPH]      = 1'b1;
    push_cmd.mask[ST_NEWLINE]    = row_end;
    push_cmd.mask[ST_END_ESC]    = frame_end;
    push_cmd.mask[ST_END_LB]     = frame_end;
    push_cmd.mask[ST_END_0]      = frame_end;
    push_cmd.mask[ST_END_M]      = frame_end;
    push_cmd.red_d               = red_d;
    push_cmd.green_d             = green_d;
    push_cmd.blue_d              = blue_d;
    push_cmd.glyph               = (in_pix.glyph == 8'd0) ? CH_SPACE : in_pix.glyph;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (push) begin
      prev_nxt = frame_end ? '0 : color;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : CNT_W'(row_inc);
      end else begin
        col_nxt = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      prev_r   <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      prev_r   <= prev_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ptat_back.sv -----
`default_nettype none
module ptat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  ptat_pkg::cmd_t head_cmd,
  output logic           pop,
  ptat_byte_if.source    out_stream
);
  import ptat_pkg::*;

`include "pixel_to_ansi_truecolor_stream_assert.svh"

  logic [NSTEP-1:0] pend_r, pend_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_done_r, out_done_nxt;

  logic [NSTEP-1:0] sel_bit, pend_left;
  step_t            sel_step;
  logic             slot_free, emit;

  always_comb begin
    sel_bit   = pend_r & (~pend_r + 1'b1);
    pend_left = pend_r & ~sel_bit;
    sel_step  = ST_HOME_ESC;
    for (int i = 0; i < NSTEP; i++) begin
      if (sel_bit[i]) begin
        sel_step = step_t'(STEP_W'(i));
      end
    end
  end

  assign slot_free = !out_valid_r || out_stream.ready;
  assign emit      = (pend_r != '0) && slot_free;
  assign pop       = head_valid && ((pend_r == '0) || (emit && (pend_left == '0)));

  always_comb begin
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_stream.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (emit) begin
      pend_nxt      = pend_left;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = step_byte(sel_step, cmd_r);
      out_last_nxt  = (pend_left == '0);
      out_done_nxt  = (sel_step == ST_END_M);
    end
    if (pop) begin
      pend_nxt = head_cmd.mask;
      cmd_nxt  = head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.out_byte    = out_byte_r;
  assign out_stream.last_of_run = out_last_r;
  assign out_stream.frame_done  = out_done_r;

  `PTAT_ASSERT_NOW(a_done_is_last, out_valid_r && out_done_r, out_last_r, "frame end not last")
  `PTAT_ASSERT_NOW(a_run_ends_right, emit && (pend_left == '0), (sel_step == ST_GLYPH) || (sel_step == ST_NEWLINE) || (sel_step == ST_END_M), "run ends on wrong byte")
  `PTAT_ASSERT_NEXT(a_one_byte_a_cycle, emit && !pop, $countones(pend_r) == $countones($past(pend_r)) - 1, "pending bytes not retired one at a time")

endmodule
`default_nettype wire

// ----- hdl/pixel_to_ansi_truecolor_stream.sv -----
// An accepted pixel passes the command queue, pending-step and output registers
// before its first byte. Throughput: one byte per cycle while the output is ready;
// a pixel gives 1 to 28 bytes, set by the byte sequencer behind the two-entry queue.
// Pixels are accepted on consecutive cycles while the queue has room.
// Reset (synchronous, active low): 80 x 24 frame, black, position home, queue and
// output register empty.
`default_nettype none
module pixel_to_ansi_truecolor_stream #(
  parameter int unsigned MAX_DIMENSION = ptat_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptat_pix_if.sink                       in_pix,
  ptat_byte_if.source                    out_stream,
  input  logic                           cfg_we,
  input  logic [ptat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptat_pkg::CFG_W-1:0]     cfg_data
);
  import ptat_pkg::*;

  logic push, push_ready, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  ptat_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  ptat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ptat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule
`default_nettype wire
